[hdl/tdpe_pkg.sv]
// ----------------------------------------------------------------------------
// tdpe_pkg: shared types and encode helpers for the Thumb-to-ARM expander
// Result record, result kinds, ARM field constants and the small opcode tables.
// ----------------------------------------------------------------------------
package tdpe_pkg;

	localparam logic [3:0] COND_AL = 4'hE;
	localparam logic [3:0] REG_SP  = 4'd13;

	// ARM data-processing opcodes used here
	localparam logic [3:0] OPC_AND = 4'd0;
	localparam logic [3:0] OPC_SUB = 4'd2;
	localparam logic [3:0] OPC_RSB = 4'd3;
	localparam logic [3:0] OPC_ADD = 4'd4;
	localparam logic [3:0] OPC_CMP = 4'd10;
	localparam logic [3:0] OPC_MOV = 4'd13;

	localparam logic [3:0] MUL_TAG = 4'd9;
	localparam logic [3:0] ROR_15  = 4'hF;

	typedef enum logic [1:0] {
		KIND_ARM   = 2'd0,
		KIND_BX    = 2'd1,
		KIND_PCREL = 2'd2,
		KIND_UNSUP = 2'd3
	} kind_t;

	typedef struct packed {
		logic [31:0] arm_word;
		kind_t       kind;
		logic [3:0]  reg_index;
		logic [7:0]  word_offset;
	} result_t;

	// ARM data-processing word, condition AL
	function automatic logic [31:0] dp_word(input logic imm, input logic [3:0] opc,
			input logic s, input logic [3:0] rn, input logic [3:0] rd,
			input logic [11:0] op2);
		return {COND_AL, 2'b00, imm, opc, s, rn, rd, op2};
	endfunction

	// move/compare/add/subtract immediate
	function automatic logic [3:0] math_imm_op(input logic [1:0] op);
		logic [3:0] r;
		case (op)
			2'd0:    r = OPC_MOV;
			2'd1:    r = OPC_CMP;
			2'd2:    r = OPC_ADD;
			default: r = OPC_SUB;
		endcase
		return r;
	endfunction

	// Thumb ALU op to ARM opcode (shifts map to MOV, NEG to RSB)
	function automatic logic [3:0] alu_op(input logic [3:0] op);
		logic [3:0] r;
		case (op)
			4'd0:    r = 4'd0;
			4'd1:    r = 4'd1;
			4'd2:    r = 4'd13;
			4'd3:    r = 4'd13;
			4'd4:    r = 4'd13;
			4'd5:    r = 4'd5;
			4'd6:    r = 4'd6;
			4'd7:    r = 4'd13;
			4'd8:    r = 4'd8;
			4'd9:    r = 4'd3;
			4'd10:   r = 4'd10;
			4'd11:   r = 4'd11;
			4'd12:   r = 4'd12;
			4'd13:   r = 4'd0;
			4'd14:   r = 4'd14;
			default: r = 4'd15;
		endcase
		return r;
	endfunction

	// shift type for register-shift ALU ops (LSL, LSR, ASR, ROR)
	function automatic logic [1:0] alu_shift_kind(input logic [2:0] op);
		logic [1:0] r;
		case (op)
			3'd3:    r = 2'd1;
			3'd4:    r = 2'd2;
			3'd7:    r = 2'd3;
			default: r = 2'd0;
		endcase
		return r;
	endfunction

	// hi-register ops: ADD, CMP, MOV (BX handled apart)
	function automatic logic [3:0] hi_op(input logic [1:0] op);
		logic [3:0] r;
		case (op)
			2'd0:    r = OPC_ADD;
			2'd1:    r = OPC_CMP;
			2'd2:    r = OPC_MOV;
			default: r = OPC_AND;
		endcase
		return r;
	endfunction

endpackage

[hdl/thumb_data_proc_to_arm_expander.sv]
// ----------------------------------------------------------------------------
// thumb_data_proc_to_arm_expander: Thumb data-processing to ARM word expander
// Input register, combinational rewrite, result register; one halfword a cycle unless the output stalls.
// ----------------------------------------------------------------------------
// Each accepted Thumb halfword yields exactly one result transaction, in order.
// The block sustains one transaction per cycle in both directions while the
// output is not stalled. A halfword taken into the input register (insn_s1) is
// rewritten and loaded into the result register (res_s2), from which it can
// leave on the result channel once valid_s2 is set. Under
// output backpressure both registers hold and the input stalls only once both
// are full. kind tells how to read the result: 0 = arm_word holds an ARM
// instruction (condition AL), 1 = BX with reg_index as target, 2 = PC-relative
// load address with reg_index and word_offset, 3 = format not expanded. Fields
// that do not apply to a kind read as zero. No configuration, no state beyond
// the two pipeline registers.
module thumb_data_proc_to_arm_expander (
	input  logic        clk,
	input  logic        arst_n,
	// Thumb halfword channel
	input  logic        thumb_valid,
	output logic        thumb_ready,
	input  logic [15:0] thumb_insn,
	// ARM result channel
	output logic        arm_valid,
	input  logic        arm_ready,
	output logic [31:0] arm_word,
	output logic [1:0]  kind,
	output logic [3:0]  reg_index,
	output logic [7:0]  word_offset
);

	logic              valid_s1;
	logic [15:0]       insn_s1;
	logic              valid_s2;
	tdpe_pkg::result_t res_s2;
	tdpe_pkg::result_t res_c;
	logic              adv_s2;

	// result register can load when empty or being drained this cycle
	assign adv_s2      = !valid_s2 || arm_ready;
	assign thumb_ready = !valid_s1 || adv_s2;

	tdpe_expand u_expand (
		.insn (insn_s1),
		.res  (res_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (thumb_ready)
				valid_s1 <= thumb_valid;
			if (adv_s2)
				valid_s2 <= valid_s1;
		end
	end

	// payload: no reset needed
	always_ff @(posedge clk) begin
		if (thumb_valid && thumb_ready)
			insn_s1 <= thumb_insn;
		if (valid_s1 && adv_s2)
			res_s2 <= res_c;
	end

	assign arm_valid   = valid_s2;
	assign arm_word    = res_s2.arm_word;
	assign kind        = res_s2.kind;
	assign reg_index   = res_s2.reg_index;
	assign word_offset = res_s2.word_offset;

`ifndef SYNTHESIS
	// an empty input stage always takes a new transaction
	a_s1_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> thumb_ready)
		else $error("input stage empty but not ready");

	// a held result whose consumer stalls survives to the next cycle
	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !arm_ready) |=> (valid_s2 && $stable(res_s2)))
		else $error("stalled result lost or changed");

	// non-ARM kinds carry no instruction word
	a_word_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.kind != tdpe_pkg::KIND_ARM) |-> (res_s2.arm_word == 32'd0))
		else $error("arm_word set for a flagged kind");

	// an ARM word always has condition AL and no register or offset fields
	a_arm_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.kind == tdpe_pkg::KIND_ARM) |->
		(res_s2.arm_word[31:28] == tdpe_pkg::COND_AL && res_s2.reg_index == 4'd0 &&
		res_s2.word_offset == 8'd0))
		else $error("bad ARM result fields");

	// offset only for PC-relative load address
	a_offset_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.word_offset != 8'd0) |-> (res_s2.kind == tdpe_pkg::KIND_PCREL))
		else $error("word_offset set outside PC-relative kind");
`endif

endmodule

[hdl/tdpe_expand.sv]
// ----------------------------------------------------------------------------
// tdpe_expand: combinational Thumb-to-ARM rewrite
// Picks the Thumb format from the top bits and builds the result record.
// ----------------------------------------------------------------------------
module tdpe_expand (
	input  logic [15:0]       insn,
	output tdpe_pkg::result_t res
);

	logic [2:0] lo_rs;
	logic [2:0] lo_rd;
	logic [2:0] hi_rd;
	logic [3:0] alu_opc;
	logic [3:0] hi_src;
	logic [3:0] hi_rn;
	logic [3:0] hi_opc;
	logic [11:0] sp_op2;
	logic [11:0] spadj_imm;

	assign lo_rs   = insn[5:3];
	assign lo_rd   = insn[2:0];
	assign hi_rd   = insn[10:8];
	assign alu_opc = tdpe_pkg::alu_op(insn[9:6]);
	assign hi_src  = {insn[6], insn[5:3]};
	assign hi_rn   = {insn[7], insn[2:0]};
	assign hi_opc  = tdpe_pkg::hi_op(insn[9:8]);

	// word8 with top bits set: rotate 15 (same as << 2)
	assign sp_op2 = (insn[7:6] != 2'b00) ? {tdpe_pkg::ROR_15, insn[7:0]}
		: {2'b00, insn[7:0], 2'b00};
	assign spadj_imm = insn[6] ? {tdpe_pkg::ROR_15, 1'b0, insn[6:0]}
		: {4'b0000, insn[5:0], 2'b00};

	always_comb begin
		res.arm_word    = '0;
		res.kind        = tdpe_pkg::KIND_ARM;
		res.reg_index   = '0;
		res.word_offset = '0;
		if (insn[15:13] == 3'b000) begin
			if (insn[12:11] != 2'b11) begin
				// shift by immediate
				res.arm_word = tdpe_pkg::dp_word(1'b0, tdpe_pkg::OPC_MOV, 1'b1, 4'd0,
					{1'b0, lo_rd}, {insn[10:6], insn[12:11], 2'b00, lo_rs});
			end else begin
				// add/subtract register or 3-bit immediate
				res.arm_word = tdpe_pkg::dp_word(insn[10],
					insn[9] ? tdpe_pkg::OPC_SUB : tdpe_pkg::OPC_ADD, 1'b1,
					{1'b0, lo_rs}, {1'b0, lo_rd}, {9'd0, insn[8:6]});
			end
		end else if (insn[15:13] == 3'b001) begin
			res.arm_word = tdpe_pkg::dp_word(1'b1, tdpe_pkg::math_imm_op(insn[12:11]),
				1'b1, {1'b0, hi_rd}, {1'b0, hi_rd}, {4'd0, insn[7:0]});
		end else if (insn[15:10] == 6'b010000) begin
			if (insn[9:6] == 4'd13) begin
				// MUL becomes MULS Rd, Rs, Rd
				res.arm_word = {tdpe_pkg::COND_AL, 7'd0, 1'b1, 1'b0, lo_rd, 4'd0,
					1'b0, lo_rs, tdpe_pkg::MUL_TAG, 1'b0, lo_rd};
			end else if (alu_opc == tdpe_pkg::OPC_MOV) begin
				// shift by register
				res.arm_word = tdpe_pkg::dp_word(1'b0, tdpe_pkg::OPC_MOV, 1'b1, 4'd0,
					{1'b0, lo_rd}, {1'b0, lo_rs, 1'b0,
					tdpe_pkg::alu_shift_kind(insn[8:6]), 1'b1, 1'b0, lo_rd});
			end else if (alu_opc == tdpe_pkg::OPC_RSB) begin
				res.arm_word = tdpe_pkg::dp_word(1'b1, tdpe_pkg::OPC_RSB, 1'b1,
					{1'b0, lo_rs}, {1'b0, lo_rd}, 12'd0);
			end else begin
				res.arm_word = tdpe_pkg::dp_word(1'b0, alu_opc, 1'b1,
					{1'b0, lo_rd}, {1'b0, lo_rd}, {9'd0, lo_rs});
			end
		end else if (insn[15:10] == 6'b010001) begin
			if (insn[9:8] == 2'b11) begin
				res.kind      = tdpe_pkg::KIND_BX;
				res.reg_index = hi_src;
			end else if (hi_opc == tdpe_pkg::OPC_CMP) begin
				res.arm_word = tdpe_pkg::dp_word(1'b0, hi_opc, 1'b1, hi_rn, 4'd0,
					{8'd0, hi_src});
			end else begin
				res.arm_word = tdpe_pkg::dp_word(1'b0, hi_opc, 1'b0, hi_rn, hi_rn,
					{8'd0, hi_src});
			end
		end else if (insn[15:12] == 4'hA) begin
			if (insn[11]) begin
				res.arm_word = tdpe_pkg::dp_word(1'b1, tdpe_pkg::OPC_ADD, 1'b0,
					tdpe_pkg::REG_SP, {1'b0, hi_rd}, sp_op2);
			end else begin
				res.kind        = tdpe_pkg::KIND_PCREL;
				res.reg_index   = {1'b0, hi_rd};
				res.word_offset = insn[7:0];
			end
		end else if (insn[15:8] == 8'hB0) begin
			res.arm_word = tdpe_pkg::dp_word(1'b1,
				insn[7] ? tdpe_pkg::OPC_SUB : tdpe_pkg::OPC_ADD, 1'b0,
				tdpe_pkg::REG_SP, tdpe_pkg::REG_SP, spadj_imm);
		end else begin
			res.kind = tdpe_pkg::KIND_UNSUP;
		end
	end

endmodule

[tb/thumb_data_proc_to_arm_expander_tb.sv]
// ----------------------------------------------------------------------------
// thumb_data_proc_to_arm_expander_tb: self-checking bench for the Thumb expander
// A short table of directed halfwords, then random halfwords weighted toward
// the expanded formats, under several idling patterns and one long output
// hold-off. Each result is checked against its table row or a local model.
// ----------------------------------------------------------------------------
module thumb_data_proc_to_arm_expander_tb;

	import tdpe_pkg::*;

	// idling patterns for the two channels
	typedef enum logic [1:0] {
		IDLE_NONE,
		IDLE_SEND,
		IDLE_RECV,
		IDLE_BOTH
	} idle_mode_t;

	// one directed row; fixed rows carry their expected result in the table
	typedef struct packed {
		logic [15:0] insn;
		logic        fixed;
		result_t     res;
	} dir_row_t;

	// one queued halfword transaction
	typedef struct packed {
		logic [15:0] insn;
		logic        fixed;
		result_t     res;
	} halfword_item_t;

	localparam int         NUM_DIR        = 25;
	localparam int         NUM_PHASES     = 5;
	localparam int         PHASE_ITEMS    = 280;
	localparam int         PRESSURE_PHASE = 4;
	localparam int         HOLD_CYCLES    = 60;
	localparam int         TAIL_CYCLES    = 8;
	localparam idle_mode_t PHASE_MODE [NUM_PHASES] =
		'{IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH, IDLE_NONE};

	localparam result_t NO_RES  = '{32'h0, KIND_ARM, 4'h0, 8'h0};
	localparam result_t UNSUP   = '{32'h0, KIND_UNSUP, 4'h0, 8'h0};
	localparam result_t BX_R15  = '{32'h0, KIND_BX, 4'd15, 8'h0};

	// Directed rows: extremes of each format, every hi-register op, MUL, NEG,
	// a register shift (ROR), both large-SP encodings, BX with H1 set, unsupported.
	localparam dir_row_t DIR_TABLE [NUM_DIR] = '{
		'{16'h0000, 1'b1, '{32'hE1B0_0000, KIND_ARM, 4'h0, 8'h0}},	// LSL r0,r0,#0
		'{16'hFFFF, 1'b1, UNSUP},					// long branch
		'{16'h4800, 1'b1, UNSUP},					// PC-relative load
		'{16'hB100, 1'b1, UNSUP},					// just past SP adjust
		'{16'h4778, 1'b1, BX_R15},					// BX r15
		'{16'h47F8, 1'b1, BX_R15},					// BX with H1 set
		'{16'hA7FF, 1'b1, '{32'h0, KIND_PCREL, 4'd7, 8'hFF}},	// ADD r7,PC,#1020
		'{16'h1FFF, 1'b0, NO_RES},					// SUB r7,r7,#7
		'{16'h17FF, 1'b0, NO_RES},					// ASR #31
		'{16'h1800, 1'b0, NO_RES},					// ADD reg
		'{16'h3FFF, 1'b0, NO_RES},					// SUB r7,#255
		'{16'h2000, 1'b0, NO_RES},					// MOV r0,#0
		'{16'h28FF, 1'b0, NO_RES},					// CMP r0,#255
		'{16'h437F, 1'b0, NO_RES},					// MUL -> MULS
		'{16'h4240, 1'b0, NO_RES},					// NEG -> RSB
		'{16'h41C0, 1'b0, NO_RES},					// ROR by register
		'{16'h43FF, 1'b0, NO_RES},					// MVN r7,r7
		'{16'h4400, 1'b0, NO_RES},					// hi ADD, H1=H2=0
		'{16'h45FF, 1'b0, NO_RES},					// hi CMP r15,r15
		'{16'h46FF, 1'b0, NO_RES},					// hi MOV r15,r15
		'{16'hAF3F, 1'b0, NO_RES},					// SP load addr, small
		'{16'hAFC0, 1'b0, NO_RES},					// SP load addr, rotate 15
		'{16'hB07F, 1'b0, NO_RES},					// ADD SP,#508
		'{16'hB0FF, 1'b0, NO_RES},					// SUB SP,#508
		'{16'hB03F, 1'b0, NO_RES}					// ADD SP,#252
	};

	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        thumb_valid = 1'b0;
	logic        thumb_ready;
	logic [15:0] thumb_insn  = 16'h0;
	logic        arm_valid;
	logic        arm_ready   = 1'b0;
	logic [31:0] arm_word;
	logic [1:0]  kind;
	logic [3:0]  reg_index;
	logic [7:0]  word_offset;

	halfword_item_t halfword_q [$];		// halfwords not yet offered
	result_t        arm_result_q [$];	// expansions awaiting their result
	halfword_item_t offered;		// halfword currently on the input port
	bit             offering    = 1'b0;
	idle_mode_t     idle_mode   = IDLE_NONE;
	bit             hold_req    = 1'b0;
	int             hold_left   = 0;
	int             mismatches  = 0;

	thumb_data_proc_to_arm_expander dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.thumb_valid (thumb_valid),
		.thumb_ready (thumb_ready),
		.thumb_insn  (thumb_insn),
		.arm_valid   (arm_valid),
		.arm_ready   (arm_ready),
		.arm_word    (arm_word),
		.kind        (kind),
		.reg_index   (reg_index),
		.word_offset (word_offset)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// ARM data-processing word with condition AL
	function automatic logic [31:0] pack_dp(input logic imm, input logic [3:0] opc,
			input logic s, input logic [3:0] rn, input logic [3:0] rd,
			input logic [11:0] op2);
		return {COND_AL, 2'b00, imm, opc, s, rn, rd, op2};
	endfunction

	// Expected expansion of one Thumb halfword
	function automatic result_t expand_thumb(input logic [15:0] t);
		result_t    r;
		logic [3:0] opc;
		logic [1:0] sk;
		logic [3:0] src;
		logic [3:0] dst;
		logic [11:0] op2;
		r = NO_RES;
		if (t[15:13] == 3'b000) begin
			if (t[12:11] != 2'b11) begin
				// shift by immediate: MOVS Rd, Rs, <shift> #off5
				r.arm_word = pack_dp(1'b0, OPC_MOV, 1'b1, 4'h0, {1'b0, t[2:0]},
					{t[10:6], t[12:11], 2'b00, t[5:3]});
			end else begin
				opc = t[9] ? OPC_SUB : OPC_ADD;
				r.arm_word = pack_dp(t[10], opc, 1'b1, {1'b0, t[5:3]}, {1'b0, t[2:0]},
					{9'h0, t[8:6]});
			end
		end else if (t[15:13] == 3'b001) begin
			case (t[12:11])
				2'd0:    opc = OPC_MOV;
				2'd1:    opc = OPC_CMP;
				2'd2:    opc = OPC_ADD;
				default: opc = OPC_SUB;
			endcase
			r.arm_word = pack_dp(1'b1, opc, 1'b1, {1'b0, t[10:8]}, {1'b0, t[10:8]},
				{4'h0, t[7:0]});
		end else if (t[15:10] == 6'b010000) begin
			if (t[9:6] == 4'd13) begin
				// MUL -> MULS Rd, Rs, Rd
				r.arm_word = {COND_AL, 7'b0, 1'b1, 1'b0, t[2:0], 4'h0, 1'b0, t[5:3],
					MUL_TAG, 1'b0, t[2:0]};
			end else begin
				case (t[9:6])
					4'd2, 4'd3, 4'd4, 4'd7: opc = OPC_MOV;
					4'd9:                   opc = OPC_RSB;
					default:                opc = t[9:6];
				endcase
				case (t[8:6])
					3'd3:    sk = 2'd1;
					3'd4:    sk = 2'd2;
					3'd7:    sk = 2'd3;
					default: sk = 2'd0;
				endcase
				if (opc == OPC_MOV)
					r.arm_word = pack_dp(1'b0, OPC_MOV, 1'b1, 4'h0, {1'b0, t[2:0]},
						{1'b0, t[5:3], 1'b0, sk, 1'b1, 1'b0, t[2:0]});
				else if (opc == OPC_RSB)
					r.arm_word = pack_dp(1'b1, OPC_RSB, 1'b1, {1'b0, t[5:3]},
						{1'b0, t[2:0]}, 12'h0);
				else
					r.arm_word = pack_dp(1'b0, opc, 1'b1, {1'b0, t[2:0]},
						{1'b0, t[2:0]}, {9'h0, t[5:3]});
			end
		end else if (t[15:10] == 6'b010001) begin
			src = {t[6], t[5:3]};
			dst = {t[7], t[2:0]};
			case (t[9:8])
				2'd0: r.arm_word = pack_dp(1'b0, OPC_ADD, 1'b0, dst, dst, {8'h0, src});
				2'd1: r.arm_word = pack_dp(1'b0, OPC_CMP, 1'b1, dst, 4'h0, {8'h0, src});
				2'd2: r.arm_word = pack_dp(1'b0, OPC_MOV, 1'b0, dst, dst, {8'h0, src});
				default: begin
					r.kind      = KIND_BX;
					r.reg_index = src;
				end
			endcase
		end else if (t[15:12] == 4'hA) begin
			if (t[11]) begin
				op2 = (t[7:6] != 2'b00) ? {ROR_15, t[7:0]} : {2'b00, t[7:0], 2'b00};
				r.arm_word = pack_dp(1'b1, OPC_ADD, 1'b0, REG_SP, {1'b0, t[10:8]}, op2);
			end else begin
				r.kind        = KIND_PCREL;
				r.reg_index   = {1'b0, t[10:8]};
				r.word_offset = t[7:0];
			end
		end else if (t[15:8] == 8'hB0) begin
			// offsets of 256 bytes and up go out as the word count, rotate 15
			op2 = t[6] ? {ROR_15, 1'b0, t[6:0]} : {3'b000, t[6:0], 2'b00};
			opc = t[7] ? OPC_SUB : OPC_ADD;
			r.arm_word = pack_dp(1'b1, opc, 1'b0, REG_SP, REG_SP, op2);
		end else begin
			r.kind = KIND_UNSUP;
		end
		return r;
	endfunction

	// Input side: offer queued halfwords, idling at random between transactions.
	// An accepted halfword gets its expected result queued right away.
	always @(posedge clk) begin
		if (arst_n) begin
			if (thumb_valid && thumb_ready) begin
				arm_result_q.push_back(offered.fixed ? offered.res
					: expand_thumb(offered.insn));
				offering = 1'b0;
			end
			if (!offering && halfword_q.size() > 0 &&
					!((idle_mode == IDLE_SEND && $urandom_range(99, 0) < 80) ||
					  (idle_mode == IDLE_BOTH && $urandom_range(99, 0) < 28))) begin
				offered = halfword_q.pop_front();
				offering = 1'b1;
				thumb_insn  <= offered.insn;
				thumb_valid <= 1'b1;
			end else if (!offering) begin
				thumb_valid <= 1'b0;
			end
		end
	end

	// Output side: check each result transaction, stall at random, and take
	// the long hold-off when asked (counted here, so the block fills up).
	always @(posedge clk) begin
		if (arst_n) begin
			if (arm_valid && arm_ready) begin
				if (arm_result_q.size() == 0) begin
					$error("result transaction with nothing expected: arm_word %h", arm_word);
					mismatches++;
				end else begin
					result_t want;
					want = arm_result_q.pop_front();
					if (arm_word !== want.arm_word) begin
						$error("arm_word expected %h actual %h", want.arm_word, arm_word);
						mismatches++;
					end
					if (kind !== want.kind) begin
						$error("kind expected %0d actual %0d", want.kind, kind);
						mismatches++;
					end
					if (reg_index !== want.reg_index) begin
						$error("reg_index expected %0d actual %0d", want.reg_index, reg_index);
						mismatches++;
					end
					if (word_offset !== want.word_offset) begin
						$error("word_offset expected %h actual %h", want.word_offset, word_offset);
						mismatches++;
					end
				end
			end
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req  = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				arm_ready <= 1'b0;
			end else begin
				arm_ready <= !((idle_mode == IDLE_RECV && $urandom_range(99, 0) < 80) ||
					(idle_mode == IDLE_BOTH && $urandom_range(99, 0) < 28));
			end
		end
	end

	// Main sequence
	initial begin
		halfword_item_t item;
		logic [15:0]    hw;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (int i = 0; i < NUM_DIR; i++) begin
			item.insn  = DIR_TABLE[i].insn;
			item.fixed = DIR_TABLE[i].fixed;
			item.res   = DIR_TABLE[i].res;
			halfword_q.push_back(item);
		end
		while (halfword_q.size() > 0 || offering || arm_result_q.size() > 0)
			@(posedge clk);

		// random phases; at least three in four halfwords hit an expanded format
		for (int p = 0; p < NUM_PHASES; p++) begin
			idle_mode = PHASE_MODE[p];
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				hw = 16'($urandom());
				case ($urandom_range(7, 0))
					0:       hw[15:13] = 3'b000;
					1:       hw[15:13] = 3'b001;
					2:       hw[15:10] = 6'b010000;
					3:       hw[15:10] = 6'b010001;
					4:       hw[15:12] = 4'hA;
					5:       hw[15:8]  = 8'hB0;
					default: ;	// anything at all
				endcase
				item.insn  = hw;
				item.fixed = 1'b0;
				item.res   = NO_RES;
				halfword_q.push_back(item);
			end
			if (p == PRESSURE_PHASE)
				hold_req = 1'b1;
			while (halfword_q.size() > 0 || offering || arm_result_q.size() > 0)
				@(posedge clk);
		end

		// let any stray result show up before the verdict
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// watchdog
	initial begin
		#2000000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
